### design/lcdpix_pkg.sv
// ----------------------------------------------------------------------------
// lcdpix_pkg
// Shared types, constants and codes for the LCD pixel-set shadow buffer.
// ----------------------------------------------------------------------------
package lcdpix_pkg;

  // display geometry defaults
  localparam int COLUMNS_DEFAULT = 84;
  localparam int ROWS_DEFAULT    = 48;
  localparam int ROWS_PER_BANK   = 8;
  localparam int BIT_SEL_W       = $clog2(ROWS_PER_BANK);
  localparam int BYTE_W          = 8;
  localparam int BANK_FIELD_W    = BYTE_W - BIT_SEL_W;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_PREFIX = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_BANK_PREFIX   = CFG_INDEX_W'(1);

  localparam logic [BYTE_W-1:0] COLUMN_PREFIX_RESET = 8'd128;
  localparam logic [BYTE_W-1:0] BANK_PREFIX_RESET   = 8'd64;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one classified pixel request
  typedef struct packed {
    logic                    rejected;
    logic [BYTE_W-1:0]       column_cmd;
    logic [BYTE_W-1:0]       bank_cmd;
    logic [BYTE_W-1:0]       column;
    logic [BANK_FIELD_W-1:0] bank;
    logic [BIT_SEL_W-1:0]    bit_sel;
  } pixel_op_t;

  localparam int PIXEL_OP_W = $bits(pixel_op_t);

  // back end sequencer
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_BANK,
    BK_DATA
  } back_state_e;

endpackage

### design/lcdpix_ram.sv
// ----------------------------------------------------------------------------
// lcdpix_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lcdpix_ram #(
  parameter int Width = 8,
  parameter int Depth = 504,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lcdpix_fifo.sv
// ----------------------------------------------------------------------------
// lcdpix_fifo
// Short queue of classified pixel requests between the front and the back.
// ----------------------------------------------------------------------------
module lcdpix_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### design/lcdpix_front.sv
// ----------------------------------------------------------------------------
// lcdpix_front
// Holds the command prefixes, range-checks each pixel and forms the command
// bytes, then pushes the classified request into the queue.
// ----------------------------------------------------------------------------
module lcdpix_front #(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lcdpix_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [lcdpix_pkg::BYTE_W-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lcdpix_pkg::BYTE_W-1:0]        pixel_column_i,
  input  logic [lcdpix_pkg::BYTE_W-1:0]        pixel_row_i,
  input  logic                                 clear_busy_i,
  input  logic                                 queue_full_i,
  output logic                                 push_o,
  output lcdpix_pkg::pixel_op_t                op_o
);

  import lcdpix_pkg::*;

  logic [BYTE_W-1:0] column_prefix_q, column_prefix_d;
  logic [BYTE_W-1:0] bank_prefix_q, bank_prefix_d;
  logic [BYTE_W-1:0] bank_byte;
  logic              off_display;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    column_prefix_d = column_prefix_q;
    bank_prefix_d   = bank_prefix_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLUMN_PREFIX: column_prefix_d = cfg_data_i;
        CFG_BANK_PREFIX:   bank_prefix_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_prefix_q <= COLUMN_PREFIX_RESET;
      bank_prefix_q   <= BANK_PREFIX_RESET;
    end else begin
      column_prefix_q <= column_prefix_d;
      bank_prefix_q   <= bank_prefix_d;
    end
  end

  // no items while the frame store is being swept clear
  assign in_ready_o = !queue_full_i && !clear_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign off_display = (9'(pixel_column_i) >= 9'(COLUMNS)) ||
                       (9'(pixel_row_i) >= 9'(ROWS));
  assign bank_byte   = pixel_row_i >> BIT_SEL_W;

  always_comb begin
    op_o.rejected   = off_display;
    op_o.column_cmd = column_prefix_q | pixel_column_i;
    op_o.bank_cmd   = bank_prefix_q | bank_byte;
    op_o.column     = pixel_column_i;
    op_o.bank       = bank_byte[BANK_FIELD_W-1:0];
    op_o.bit_sel    = pixel_row_i[BIT_SEL_W-1:0];
  end

endmodule

### design/lcdpix_back.sv
// ----------------------------------------------------------------------------
// lcdpix_back
// Clears the frame store after reset, then takes requests from the queue,
// does the read-modify-write of the shadow byte and emits the three bytes
// through an output register; a rejected request gives one lone result.
// ----------------------------------------------------------------------------
module lcdpix_back #(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          queue_valid_i,
  input  lcdpix_pkg::pixel_op_t         queue_op_i,
  output logic                          pop_o,
  output logic                          clear_busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lcdpix_pkg::BYTE_W-1:0] lcd_byte_o,
  output logic                          is_data_o,
  output logic                          rejected_o,
  output logic                          last_o
);

  import lcdpix_pkg::*;

  localparam int Banks = (ROWS + ROWS_PER_BANK - 1) / ROWS_PER_BANK;
  localparam int Depth = COLUMNS * Banks;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  back_state_e state_q, state_d;

  logic [AddrW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic [BYTE_W-1:0]    bank_cmd_q, bank_cmd_d;
  logic [BIT_SEL_W-1:0] bit_sel_q, bit_sel_d;
  logic [15:0]          addr_full;
  logic                 can_load;

  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    lcd_byte_q, lcd_byte_d;
  logic                 is_data_q, is_data_d;
  logic                 rejected_q, rejected_d;
  logic                 last_q, last_d;
  logic                 load;

  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_waddr;
  logic [BYTE_W-1:0]    ram_wdata, ram_rdata;

  // output register free this cycle
  assign can_load = !out_valid_q || out_ready_i;

  // column-major layout, one byte per column and bank
  assign addr_full = 16'(queue_op_i.column) * 16'(Banks) + 16'(queue_op_i.bank);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: begin
        if (clr_cnt_q == AddrW'(Depth - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (queue_valid_i && can_load && !queue_op_i.rejected) begin
          state_d = BK_BANK;
        end
      end
      BK_BANK: begin
        if (can_load) begin
          state_d = BK_DATA;
        end
      end
      BK_DATA: begin
        if (can_load) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    addr_d     = addr_q;
    bank_cmd_d = bank_cmd_q;
    bit_sel_d  = bit_sel_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    lcd_byte_d = lcd_byte_q;
    is_data_d  = is_data_q;
    rejected_d = rejected_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = ram_rdata | (BYTE_W'(1) << bit_sel_q);
    ram_re     = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
      end
      BK_IDLE: begin
        if (queue_valid_i && can_load) begin
          pop_o = 1'b1;
          load  = 1'b1;
          if (queue_op_i.rejected) begin
            lcd_byte_d = '0;
            is_data_d  = 1'b0;
            rejected_d = 1'b1;
            last_d     = 1'b1;
          end else begin
            lcd_byte_d = queue_op_i.column_cmd;
            is_data_d  = 1'b0;
            rejected_d = 1'b0;
            last_d     = 1'b0;
            ram_re     = 1'b1;
            addr_d     = addr_full[AddrW-1:0];
            bank_cmd_d = queue_op_i.bank_cmd;
            bit_sel_d  = queue_op_i.bit_sel;
          end
        end
      end
      BK_BANK: begin
        if (can_load) begin
          load       = 1'b1;
          lcd_byte_d = bank_cmd_q;
          is_data_d  = 1'b0;
          rejected_d = 1'b0;
          last_d     = 1'b0;
        end
      end
      BK_DATA: begin
        if (can_load) begin
          // read data is held since the read was issued on pop
          load       = 1'b1;
          ram_we     = 1'b1;
          lcd_byte_d = ram_wdata;
          is_data_d  = 1'b1;
          rejected_d = 1'b0;
          last_d     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    bank_cmd_q <= bank_cmd_d;
    bit_sel_q  <= bit_sel_d;
    lcd_byte_q <= lcd_byte_d;
    is_data_q  <= is_data_d;
    rejected_q <= rejected_d;
    last_q     <= last_d;
  end

  lcdpix_ram #(
    .Width (BYTE_W),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_full[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign clear_busy_o = (state_q == BK_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign lcd_byte_o   = lcd_byte_q;
  assign is_data_o    = is_data_q;
  assign rejected_o   = rejected_q;
  assign last_o       = last_q;

endmodule

### design/lcd_pixel_set_shadow_buffer.sv
// ----------------------------------------------------------------------------
// lcd_pixel_set_shadow_buffer
// Pixel set for a bank-organised monochrome LCD with a shadow frame store.
// ----------------------------------------------------------------------------
// path: the first byte goes through the queue, then the output register; an
//   off-display pixel gives its single rejected result the same way
// output: three bytes per on-display pixel, one per rejected one; the queue
//   takes further pixels while the back end works through the bytes of one
// reset: prefixes return to 128 and 64; the frame store is swept to zero,
//   one byte a cycle over all COLUMNS*banks bytes (504 by default), with no
//   pixels taken; configuration writes are taken throughout
module lcd_pixel_set_shadow_buffer #(
  parameter int COLUMNS = lcdpix_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = lcdpix_pkg::ROWS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lcdpix_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [lcdpix_pkg::BYTE_W-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lcdpix_pkg::BYTE_W-1:0]       pixel_column_i,
  input  logic [lcdpix_pkg::BYTE_W-1:0]       pixel_row_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lcdpix_pkg::BYTE_W-1:0]       lcd_byte_o,
  output logic                                is_data_o,
  output logic                                rejected_o,
  output logic                                last_o
);

  import lcdpix_pkg::*;

  pixel_op_t front_op;
  pixel_op_t queue_op;
  logic      push, pop, queue_full, queue_valid, clear_busy;
  logic [PIXEL_OP_W-1:0] queue_rdata;

  lcdpix_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .clear_busy_i   (clear_busy),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .op_o           (front_op)
  );

  lcdpix_fifo #(
    .Width (PIXEL_OP_W),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_op),
    .full_o  (queue_full),
    .pop_i   (pop),
    .rdata_o (queue_rdata),
    .valid_o (queue_valid)
  );

  assign queue_op = pixel_op_t'(queue_rdata);

  lcdpix_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (queue_valid),
    .queue_op_i    (queue_op),
    .pop_o         (pop),
    .clear_busy_o  (clear_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lcd_byte_o    (lcd_byte_o),
    .is_data_o     (is_data_o),
    .rejected_o    (rejected_o),
    .last_o        (last_o)
  );

endmodule

### design/lcdpix_checker.sv
// ----------------------------------------------------------------------------
// lcdpix_checker
// Port-level checks on the result stream of the pixel-set block.
// ----------------------------------------------------------------------------
module lcdpix_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [lcdpix_pkg::BYTE_W-1:0]       lcd_byte_o,
  input logic                                is_data_o,
  input logic                                rejected_o,
  input logic                                last_o
);

  // a rejected result stands alone and carries a zero byte
  a_reject_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> last_o && !is_data_o && (lcd_byte_o == 8'd0))
    else $error("rejected result not a lone zero command");

  // the data byte closes the three-byte group
  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_data_o |-> last_o && !rejected_o)
    else $error("data byte not marked last");

  // only command bytes of an on-display pixel are not last
  a_not_last_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !is_data_o && !rejected_o)
    else $error("non-last result is not a command byte");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lcd_byte_o) &&
      $stable(is_data_o) && $stable(rejected_o) && $stable(last_o))
    else $error("result dropped or changed while stalled");

endmodule

bind lcd_pixel_set_shadow_buffer lcdpix_checker u_checker (.*);
